/* hdl/char_stream_tokenizer_macros.svh */
// Assertion macros used by the tokenizer scan core
`ifndef CHAR_STREAM_TOKENIZER_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_MACROS_SVH

// Check cons in the same cycle as ante; uses clk and rst_n of the enclosing module
`define CST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cst_pkg.sv */
// Shared types and constants of the character stream tokenizer
package cst_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAL_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_ENABLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ENABLE  = 3'd6;

    localparam int CFG_DATA_W = 64;

    // Register defaults: underscore is a symbol char, TAB/LF/CR/space are skipped
    localparam logic [CFG_DATA_W-1:0] SYMBOL_HIGH_RESET = 64'h0000_0000_8000_0000;
    localparam logic [CFG_DATA_W-1:0] SKIP_LOW_RESET    = 64'h0000_0001_0000_2600;

    // Result field widths
    localparam int CHAR_W     = 8;
    localparam int TEXT_POS_W = 6;
    localparam int CLASS_W    = 3;

    // Event codes
    localparam logic EV_APPEND   = 1'b0;
    localparam logic EV_COMPLETE = 1'b1;

    // Token class codes on a complete event
    localparam logic [CLASS_W-1:0] TC_SINGLE  = 3'd0;
    localparam logic [CLASS_W-1:0] TC_SYMBOL  = 3'd1;
    localparam logic [CLASS_W-1:0] TC_REAL    = 3'd2;
    localparam logic [CLASS_W-1:0] TC_DECIMAL = 3'd3;
    localparam logic [CLASS_W-1:0] TC_OCTAL   = 3'd4;
    localparam logic [CLASS_W-1:0] TC_HEX     = 3'd5;
    localparam logic [CLASS_W-1:0] TC_END     = 3'd6;

    // Result queue depth
    localparam int RESULT_DEPTH = 4;

    // Scanner state
    typedef enum logic [1:0] {
        PS_INIT,
        PS_NEW,
        PS_SKIP,
        PS_MORE
    } parse_state_t;

    // Class of the token being built
    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_SYM  = 3'd1,
        CLS_REAL = 3'd2,
        CLS_INT  = 3'd3,
        CLS_DOT  = 3'd4,
        CLS_END  = 3'd6
    } token_kind_t;

    // Number subtype
    typedef enum logic [2:0] {
        SUB_NONE = 3'd0,
        SUB_MAN  = 3'd1,
        SUB_EXP  = 3'd2,
        SUB_DEC  = 3'd3,
        SUB_OCT  = 3'd4,
        SUB_HEX  = 3'd5
    } number_sub_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] symbol_low;
        logic [CFG_DATA_W-1:0] symbol_high;
        logic [CFG_DATA_W-1:0] skip_low;
        logic [CFG_DATA_W-1:0] skip_high;
        logic                  octal_enable;
        logic                  hex_enable;
        logic                  real_enable;
    } cfg_t;

    typedef struct packed {
        logic                  event_res;
        logic [CHAR_W-1:0]     char_value;
        logic [TEXT_POS_W-1:0] text_position;
        logic [CLASS_W-1:0]    token_class;
        logic                  overflow;
        logic                  last;
    } result_t;

endpackage

/* hdl/cst_char_if.sv */
// Character input channel of the tokenizer
interface cst_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

/* hdl/cst_token_if.sv */
// Result channel of the tokenizer: append and token complete events
interface cst_token_if;
    logic       valid;
    logic       ready;
    logic       event_res;
    logic [7:0] char_value;
    logic [5:0] text_position;
    logic [2:0] token_class;
    logic       overflow;
    logic       last;

    modport source (
        output valid, output event_res, output char_value, output text_position,
        output token_class, output overflow, output last, input ready
    );
    modport sink (
        input valid, input event_res, input char_value, input text_position,
        input token_class, input overflow, input last, output ready
    );
endinterface

/* hdl/cst_scan_core.sv */
// Scanner state machine: one character item in, up to two results out
`include "char_stream_tokenizer_macros.svh"

module cst_scan_core #(
    parameter int MAX_TOKEN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [7:0]                  char_code,
    input  cst_pkg::cfg_t               cfg,
    output cst_pkg::result_t [1:0]      res,
    output logic [1:0]                  res_count
);

    localparam int WPOS_W = $clog2(MAX_TOKEN + 1);
    localparam logic [WPOS_W-1:0] MAX_POS  = WPOS_W'(MAX_TOKEN);
    localparam logic [WPOS_W-1:0] LAST_POS = WPOS_W'(MAX_TOKEN - 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    cst_pkg::parse_state_t ps_reg, ps_next;
    cst_pkg::token_kind_t  cls_reg, cls_next;
    cst_pkg::number_sub_t  sub_reg, sub_next;
    logic [7:0]            prev_reg, prev_next;
    logic [7:0]            pc_reg, pc_next;
    logic                  pv_reg, pv_next;
    logic [WPOS_W-1:0]     wpos_reg, wpos_next;
    logic                  ovf_reg, ovf_next;

    function automatic logic in_set(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (c != CH_NUL && !c[7])
        begin
            hit = c[6] ? hi[c[5:0]] : lo[c[5:0]];
        end
        return hit;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
    endfunction

    function automatic logic is_hexl(input logic [7:0] c);
        return c inside {[CH_0:CH_9], [CH_LA:CH_LF]};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[CH_UA:CH_UZ]}) ? c + CASE_OFFSET : c;
    endfunction

    // Hold scanner state; advance only when an item is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg   <= cst_pkg::PS_INIT;
            cls_reg  <= cst_pkg::CLS_NONE;
            sub_reg  <= cst_pkg::SUB_NONE;
            prev_reg <= '0;
            pc_reg   <= '0;
            pv_reg   <= 1'b0;
            wpos_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (fire)
        begin
            ps_reg   <= ps_next;
            cls_reg  <= cls_next;
            sub_reg  <= sub_next;
            prev_reg <= prev_next;
            pc_reg   <= pc_next;
            pv_reg   <= pv_next;
            wpos_reg <= wpos_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Replay the pushback char, then the new char; at most two passes
    always_comb
    begin
        logic [7:0]        c;
        logic [7:0]        cl;
        logic              push;
        logic              go;
        logic              more;
        logic              skip_hit;
        logic [WPOS_W-1:0] pos;
        logic [1:0]        n;
        cst_pkg::result_t  r;

        ps_next   = ps_reg;
        cls_next  = cls_reg;
        sub_next  = sub_reg;
        prev_next = prev_reg;
        pc_next   = pc_reg;
        pv_next   = pv_reg;
        wpos_next = wpos_reg;
        ovf_next  = ovf_reg;
        res       = '0;
        c         = char_code;
        cl        = '0;
        push      = 1'b0;
        go        = 1'b1;
        more      = 1'b0;
        skip_hit  = 1'b0;
        pos       = '0;
        n         = 2'd0;
        r         = '0;

        // Start of stream: drop any pushback
        if (ps_next == cst_pkg::PS_INIT)
        begin
            pv_next   = 1'b0;
            prev_next = '0;
            ps_next   = cst_pkg::PS_NEW;
        end

        // Start of a token: clear text, pick up the pushback char
        if (ps_next == cst_pkg::PS_NEW)
        begin
            ps_next   = cst_pkg::PS_SKIP;
            cls_next  = cst_pkg::CLS_NONE;
            wpos_next = '0;
            ovf_next  = 1'b0;
            if (pv_next)
            begin
                c       = pc_next;
                pv_next = 1'b0;
                push    = 1'b1;
            end
        end

        for (int it = 0; it < 2; it++)
        begin
            if (go)
            begin
                go       = 1'b0;
                cl       = to_lower(c);
                more     = 1'b1;
                skip_hit = 1'b0;

                if (ps_next == cst_pkg::PS_SKIP)
                begin
                    // Skip delimiters, else classify the first char
                    if (in_set(cfg.skip_low, cfg.skip_high, c))
                    begin
                        skip_hit = 1'b1;
                    end
                    else
                    begin
                        ps_next  = cst_pkg::PS_MORE;
                        cls_next = cst_pkg::CLS_NONE;
                        if (c == CH_NUL)
                        begin
                            cls_next = cst_pkg::CLS_END;
                            more     = 1'b0;
                        end
                        else if (is_digit(c))
                        begin
                            cls_next = cst_pkg::CLS_INT;
                            sub_next = (cfg.octal_enable && c == CH_0) ?
                                       cst_pkg::SUB_OCT : cst_pkg::SUB_DEC;
                        end
                        else if (is_alpha(c) || in_set(cfg.symbol_low, cfg.symbol_high, c))
                        begin
                            cls_next = cst_pkg::CLS_SYM;
                        end
                        else if (!cfg.real_enable || c != CH_DOT)
                        begin
                            ps_next = cst_pkg::PS_NEW;
                            more    = 1'b0;
                        end
                        else
                        begin
                            cls_next = cst_pkg::CLS_DOT;
                        end
                    end
                end
                else
                begin
                    // Extend the current token or end it
                    case (cls_next)
                        cst_pkg::CLS_INT:
                        begin
                            if (sub_next == cst_pkg::SUB_DEC && is_digit(c))
                            begin
                                more = 1'b1;
                            end
                            else if (cfg.octal_enable && sub_next == cst_pkg::SUB_OCT &&
                                     (c inside {[CH_0:CH_7]}))
                            begin
                                more = 1'b1;
                            end
                            else if (cfg.hex_enable && sub_next == cst_pkg::SUB_HEX &&
                                     is_hexl(cl))
                            begin
                                // First hex digit overwrites the prefix
                                if (prev_next == CH_LX)
                                begin
                                    wpos_next = '0;
                                end
                            end
                            else if (cfg.hex_enable && wpos_next == WPOS_W'(1) &&
                                     cl == CH_LX && prev_next == CH_0)
                            begin
                                sub_next = cst_pkg::SUB_HEX;
                            end
                            else if (cfg.real_enable && sub_next != cst_pkg::SUB_HEX &&
                                     (c == CH_DOT || cl == CH_LE))
                            begin
                                cls_next = cst_pkg::CLS_REAL;
                                sub_next = (c == CH_DOT) ? cst_pkg::SUB_MAN : cst_pkg::SUB_EXP;
                            end
                            else
                            begin
                                more = 1'b0;
                            end
                        end
                        cst_pkg::CLS_REAL:
                        begin
                            if (is_digit(c))
                            begin
                                more = 1'b1;
                            end
                            else if ((c == CH_PLUS || c == CH_MINUS) && prev_next == CH_LE)
                            begin
                                more = 1'b1;
                            end
                            else if (cl == CH_LE && sub_next != cst_pkg::SUB_EXP)
                            begin
                                sub_next = cst_pkg::SUB_EXP;
                            end
                            else
                            begin
                                more = 1'b0;
                            end
                        end
                        cst_pkg::CLS_DOT:
                        begin
                            more = is_digit(c);
                            if (more)
                            begin
                                cls_next = cst_pkg::CLS_REAL;
                                sub_next = cst_pkg::SUB_MAN;
                            end
                        end
                        cst_pkg::CLS_SYM:
                        begin
                            more = is_digit(c) || is_alpha(c) ||
                                   in_set(cfg.symbol_low, cfg.symbol_high, c);
                        end
                        default:
                        begin
                            more = 1'b0;
                        end
                    endcase
                    // Push back the char that ended the token
                    if (!more)
                    begin
                        pc_next = c;
                        pv_next = 1'b1;
                    end
                end

                prev_next = cl;

                if (skip_hit)
                begin
                    if (push)
                    begin
                        c    = char_code;
                        push = 1'b0;
                        go   = 1'b1;
                    end
                end
                else if (more)
                begin
                    // Append, saturating at the last text position
                    pos = wpos_next;
                    if (pos >= MAX_POS)
                    begin
                        pos      = LAST_POS;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wpos_next = pos + WPOS_W'(1);
                    end
                    r               = '0;
                    r.event_res     = cst_pkg::EV_APPEND;
                    r.char_value    = c;
                    r.text_position = cst_pkg::TEXT_POS_W'(pos);
                    r.overflow      = ovf_next;
                    if (n == 2'd0)
                    begin
                        res[0] = r;
                    end
                    else
                    begin
                        res[1] = r;
                    end
                    n = n + 2'd1;
                    if (push)
                    begin
                        c    = char_code;
                        push = 1'b0;
                        go   = 1'b1;
                    end
                end
                else
                begin
                    // Complete the token; a replayed char parks the new one
                    if (push)
                    begin
                        pc_next = char_code;
                        pv_next = 1'b1;
                        push    = 1'b0;
                    end
                    r           = '0;
                    r.event_res = cst_pkg::EV_COMPLETE;
                    r.overflow  = ovf_next;
                    case (cls_next)
                        cst_pkg::CLS_NONE: r.char_value  = c;
                        cst_pkg::CLS_DOT:  r.char_value  = CH_DOT;
                        cst_pkg::CLS_SYM:  r.token_class = cst_pkg::TC_SYMBOL;
                        cst_pkg::CLS_REAL: r.token_class = cst_pkg::TC_REAL;
                        cst_pkg::CLS_END:  r.token_class = cst_pkg::TC_END;
                        cst_pkg::CLS_INT:
                        begin
                            r.token_class = cst_pkg::TC_DECIMAL;
                            if (cfg.octal_enable || cfg.hex_enable)
                            begin
                                case (sub_next)
                                    cst_pkg::SUB_OCT: r.token_class = cst_pkg::TC_OCTAL;
                                    cst_pkg::SUB_HEX: r.token_class = cst_pkg::TC_HEX;
                                    default:          r.token_class = cst_pkg::TC_DECIMAL;
                                endcase
                            end
                        end
                        default: r.char_value = CH_NUL;
                    endcase
                    if (n == 2'd0)
                    begin
                        res[0] = r;
                    end
                    else
                    begin
                        res[1] = r;
                    end
                    n       = n + 2'd1;
                    ps_next = (cls_next == cst_pkg::CLS_END) ? cst_pkg::PS_INIT :
                                                               cst_pkg::PS_NEW;
                end
            end
        end

        // Mark the final result of this item
        if (n == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res[1].last = 1'b1;
        end
        res_count = n;
    end

    `CST_ASSERT_IMPL(a_pair_starts_with_append, fire && res_count == 2'd2, res[0].event_res == cst_pkg::EV_APPEND, "two results must begin with an append")
    `CST_ASSERT_IMPL(a_position_bounded, 1'b1, wpos_reg <= MAX_POS, "write position beyond token limit")
    `CST_ASSERT_IMPL(a_overflow_at_limit, ovf_reg, wpos_reg == MAX_POS, "overflow set below the token limit")
    `CST_ASSERT_NEXT(a_end_restarts, fire && res_count != 2'd0 && res[0].event_res == cst_pkg::EV_COMPLETE && res[0].token_class == cst_pkg::TC_END, ps_reg == cst_pkg::PS_INIT, "end token must return to the start state")

endmodule

/* hdl/cst_result_fifo.sv */
// Result queue that takes up to two results per cycle and sends one per cycle while tokens.ready is high
module cst_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             push_count,
    input  cst_pkg::result_t [1:0] push_data,
    output logic                   room,
    cst_token_if.source            tokens
);

    localparam int DEPTH = cst_pkg::RESULT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cst_pkg::result_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              pop;
    cst_pkg::result_t  head;

    assign pop  = tokens.valid && tokens.ready;
    assign room = count_reg <= CNT_W'(DEPTH - 2);
    assign head = entry_reg[rd_ptr_reg];

    // Drive the head entry onto the channel
    assign tokens.valid         = count_reg != '0;
    assign tokens.event_res     = head.event_res;
    assign tokens.char_value    = head.char_value;
    assign tokens.text_position = head.text_position;
    assign tokens.token_class   = head.token_class;
    assign tokens.overflow      = head.overflow;
    assign tokens.last          = head.last;

    // Store new results at the tail
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data[1];
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_count) - CNT_W'(pop);
        end
    end

endmodule

/* hdl/char_stream_tokenizer.sv */
// Top level of the character stream tokenizer
//
// chars carries one character per item (0 ends the stream); tokens carries
// append events (char and text position) and token complete events (class).
// An item gives zero, one or two results; the last one has last set.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle; the block does not enforce this. Each item
// is scanned from the input register into the queue; tokens shows its head.
// Throughput: one item per cycle while each gives at most one result and
// tokens.ready is high; the two results of one item go out in turn. The
// scanner step itself is one pass of logic between the input register and a
// four-entry result queue.
// Reset: configuration takes its defaults (underscore a symbol char, TAB, LF,
// CR and space skipped, octal, hex and reals on), the scanner goes to its
// start state with no pushback and the queue empties.
// Stall: when tokens.ready is low the queue fills; scanning stops once fewer
// than two entries are free, the input register holds its item and
// chars.ready drops.
module char_stream_tokenizer #(
    parameter int MAX_TOKEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cst_char_if.sink                            chars,
    cst_token_if.source                         tokens,
    input  logic                                cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cst_pkg::CFG_DATA_W-1:0]      cfg_data
);

    cst_pkg::cfg_t          cfg_reg;
    logic                   char_valid_reg;
    logic [7:0]             char_reg;
    logic                   room;
    logic                   fire;
    cst_pkg::result_t [1:0] res;
    logic [1:0]             res_count;
    logic [1:0]             push_count;

    // Scan when an item waits and the queue has room for two results
    assign fire        = char_valid_reg && room;
    assign chars.ready = !char_valid_reg || fire;
    assign push_count  = fire ? res_count : 2'd0;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.symbol_low   <= '0;
            cfg_reg.symbol_high  <= cst_pkg::SYMBOL_HIGH_RESET;
            cfg_reg.skip_low     <= cst_pkg::SKIP_LOW_RESET;
            cfg_reg.skip_high    <= '0;
            cfg_reg.octal_enable <= 1'b1;
            cfg_reg.hex_enable   <= 1'b1;
            cfg_reg.real_enable  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cst_pkg::CFG_SYMBOL_LOW:   cfg_reg.symbol_low   <= cfg_data;
                cst_pkg::CFG_SYMBOL_HIGH:  cfg_reg.symbol_high  <= cfg_data;
                cst_pkg::CFG_SKIP_LOW:     cfg_reg.skip_low     <= cfg_data;
                cst_pkg::CFG_SKIP_HIGH:    cfg_reg.skip_high    <= cfg_data;
                cst_pkg::CFG_OCTAL_ENABLE: cfg_reg.octal_enable <= cfg_data[0];
                cst_pkg::CFG_HEX_ENABLE:   cfg_reg.hex_enable   <= cfg_data[0];
                cst_pkg::CFG_REAL_ENABLE:  cfg_reg.real_enable  <= cfg_data[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Track the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            char_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            char_valid_reg <= 1'b0;
        end
    end

    // Load the input character
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_in;
        end
    end

    cst_scan_core #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_scan_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (char_reg),
        .cfg       (cfg_reg),
        .res       (res),
        .res_count (res_count)
    );

    cst_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (res),
        .room       (room),
        .tokens     (tokens)
    );

endmodule
